### rtl/fpa_pkg.sv
// Shared action codes, item classes and the queued item type.
package fpa_pkg;

  localparam logic [3:0] ACT_ADD      = 4'd0;
  localparam logic [3:0] ACT_SUB      = 4'd1;
  localparam logic [3:0] ACT_MUL      = 4'd2;
  localparam logic [3:0] ACT_DIV      = 4'd3;
  localparam logic [3:0] ACT_MIN      = 4'd4;
  localparam logic [3:0] ACT_MAX      = 4'd5;
  localparam logic [3:0] ACT_INC      = 4'd6;
  localparam logic [3:0] ACT_DEC      = 4'd7;
  localparam logic [3:0] ACT_FROM_INT = 4'd8;
  localparam logic [3:0] ACT_TO_INT   = 4'd9;

  localparam logic [1:0] CLS_SIMPLE = 2'd0;
  localparam logic [1:0] CLS_MUL    = 2'd1;
  localparam logic [1:0] CLS_DIV    = 2'd2;

  typedef struct packed {
    logic [1:0]         cls;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0]        res;
    logic               less;
    logic               equal;
    logic               greater;
  } fpa_item_t;

endpackage

### rtl/fpa_if.sv
// Valid/ready channel interfaces for input and result items.
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         action;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               less;
  logic               equal;
  logic               greater;
  logic               divide_by_zero;
  modport source (output valid, result, less, equal, greater, divide_by_zero, input ready);
  modport sink   (input valid, result, less, equal, greater, divide_by_zero, output ready);
endinterface

### rtl/fpa_front.sv
// Front end: classifies each item, computes flags and the results of the simple actions.
module fpa_front import fpa_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic [3:0]         action,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output fpa_item_t          item
);

  always_comb begin
    item.cls     = CLS_SIMPLE;
    item.a       = operand_a;
    item.b       = operand_b;
    item.less    = operand_a < operand_b;
    item.equal   = operand_a == operand_b;
    item.greater = operand_a > operand_b;
    item.res     = '0;
    unique case (action)
      ACT_ADD:      item.res = operand_a + operand_b;
      ACT_SUB:      item.res = operand_a - operand_b;
      ACT_MUL:      item.cls = CLS_MUL;
      ACT_DIV:      item.cls = CLS_DIV;
      ACT_MIN:      item.res = (operand_a < operand_b) ? operand_a : operand_b;
      ACT_MAX:      item.res = (operand_a > operand_b) ? operand_a : operand_b;
      ACT_INC:      item.res = operand_a + 32'sd1;
      ACT_DEC:      item.res = operand_a - 32'sd1;
      ACT_FROM_INT: item.res = operand_a << FRACTION_BITS;
      ACT_TO_INT:   item.res = operand_a >>> FRACTION_BITS;
      default:      item.res = '0;
    endcase
  end

endmodule

### rtl/fpa_queue.sv
// Two-entry queue between front and back.
module fpa_queue import fpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  fpa_item_t push_item,
  output logic      full,
  input  logic      pop,
  output fpa_item_t pop_item,
  output logic      nonempty
);

  fpa_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign nonempty = cnt_r != 2'd0;
  assign pop_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/fpa_back.sv
// Back end: multiplier and one-bit-per-stage divider pipeline with output stage.
module fpa_back import fpa_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  fpa_item_t q_item,
  output logic      q_pop,
  fpa_out_if.source out_ch
);

  localparam int DW = 32 + FRACTION_BITS;
  localparam int L  = DW + 2;

  typedef struct packed {
    logic [1:0]    cls;
    logic          less;
    logic          equal;
    logic          greater;
    logic          dz;
    logic [31:0]   res;
    logic          qneg;
    logic [32:0]   rem;
    logic [DW-1:0] quo;
    logic [31:0]   dvs;
  } fpa_stage_t;

  fpa_stage_t         st_r   [L];
  fpa_stage_t         st_nxt [L];
  logic               v_r    [L];
  logic signed [63:0] prod_r;
  logic               en;

  assign en    = !v_r[L-1] || out_ch.ready;
  assign q_pop = en && q_valid;

  always_comb begin
    logic [32:0]        tmp;
    logic [31:0]        mag_a;
    logic signed [63:0] sh;
    logic [DW-1:0]      qs;
    mag_a = q_item.a[31] ? 32'(-q_item.a) : 32'(q_item.a);
    st_nxt[0].cls     = q_item.cls;
    st_nxt[0].less    = q_item.less;
    st_nxt[0].equal   = q_item.equal;
    st_nxt[0].greater = q_item.greater;
    st_nxt[0].dz      = (q_item.cls == CLS_DIV) && (q_item.b == 32'sd0);
    st_nxt[0].res     = q_item.res;
    st_nxt[0].qneg    = q_item.a[31] ^ q_item.b[31];
    st_nxt[0].rem     = '0;
    st_nxt[0].quo     = {mag_a, {FRACTION_BITS{1'b0}}};
    st_nxt[0].dvs     = q_item.b[31] ? 32'(-q_item.b) : 32'(q_item.b);
    sh = prod_r >>> FRACTION_BITS;
    for (int k = 1; k <= DW; k++) begin
      st_nxt[k] = st_r[k-1];
      tmp = {st_r[k-1].rem[31:0], st_r[k-1].quo[DW-1]};
      if (tmp >= {1'b0, st_r[k-1].dvs}) begin
        st_nxt[k].rem = tmp - {1'b0, st_r[k-1].dvs};
        st_nxt[k].quo = {st_r[k-1].quo[DW-2:0], 1'b1};
      end else begin
        st_nxt[k].rem = tmp;
        st_nxt[k].quo = {st_r[k-1].quo[DW-2:0], 1'b0};
      end
      if (k == 1 && st_r[0].cls == CLS_MUL) st_nxt[k].res = sh[31:0];
    end
    st_nxt[L-1] = st_r[L-2];
    qs = st_r[L-2].qneg ? -st_r[L-2].quo : st_r[L-2].quo;
    if (st_r[L-2].cls == CLS_DIV) st_nxt[L-1].res = st_r[L-2].dz ? 32'd0 : qs[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= q_item.a * q_item.b;
      for (int k = 0; k < L; k++) st_r[k] <= st_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= q_valid;
      for (int k = 1; k < L; k++) v_r[k] <= v_r[k-1];
    end
  end

  assign out_ch.valid          = v_r[L-1];
  assign out_ch.result         = st_r[L-1].res;
  assign out_ch.less           = st_r[L-1].less;
  assign out_ch.equal          = st_r[L-1].equal;
  assign out_ch.greater        = st_r[L-1].greater;
  assign out_ch.divide_by_zero = st_r[L-1].dz;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[L-1] && st_r[L-1].dz |-> st_r[L-1].res == 32'd0)
    else $error("divide by zero result not zero");
  a_dz_div: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[L-1] && st_r[L-1].dz |-> st_r[L-1].cls == CLS_DIV)
    else $error("divide by zero flag on non-divide item");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[L-1] |-> $onehot({st_r[L-1].less, st_r[L-1].equal, st_r[L-1].greater}))
    else $error("compare flags not one-hot");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> v_r[0] == $past(v_r[0]) && v_r[L-1] == $past(v_r[L-1]))
    else $error("pipeline moved while stalled");

endmodule

### rtl/fixed_point_q24_8_alu_core.sv
// Top level of the signed Q24.8 fixed-point arithmetic unit.
// One item is taken per clock while the queue is not full, and one result
// item comes back per item, in order. Every action runs through the same
// pipeline: the queue, one entry stage, one stage per quotient bit over the
// 32+FRACTION_BITS-bit dividend, and the sign/output stage. Multiply is a
// registered 32x32 product followed by an arithmetic shift. A two-entry
// queue decouples the input from the back pipeline; when the result is not
// taken the whole back pipeline holds and the queue fills, then in_ch.ready
// drops. Flags less/equal/greater compare operand_a with operand_b for every
// action; divide by zero gives 0 with divide_by_zero set, and unused action
// codes give 0.
module fixed_point_q24_8_alu_core import fpa_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  fpa_in_if.sink   in_ch,
  fpa_out_if.source out_ch
);

  fpa_item_t f_item, q_item;
  logic      q_full, q_nonempty, q_pop;

  // front: classify and do the simple actions
  fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .action    (in_ch.action),
    .operand_a (in_ch.operand_a),
    .operand_b (in_ch.operand_b),
    .item      (f_item)
  );

  assign in_ch.ready = !q_full;

  fpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_ch.valid && !q_full),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .nonempty  (q_nonempty)
  );

  // back: multiply, divide and the output stage
  fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_nonempty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### sim/tb_fpa_if.sv
// Scoreboard package for the fixed-point ALU testbench.
`timescale 1ns / 100ps
package tb_fpa_sb_pkg;

  typedef struct {
    logic signed [31:0] result;
    logic               less;
    logic               equal;
    logic               greater;
    logic               dz;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t pending[$];
    int       errors;

    function void note_item(alu_res_t r);
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(alu_res_t got);
      alu_res_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("result item with nothing pending: %h", got.result));
        return;
      end
      exp_r = pending.pop_front();
      if (got.result !== exp_r.result || got.less !== exp_r.less ||
          got.equal !== exp_r.equal || got.greater !== exp_r.greater ||
          got.dz !== exp_r.dz) begin
        report($sformatf("got %h %b%b%b %b expected %h %b%b%b %b",
                         got.result, got.less, got.equal, got.greater, got.dz,
                         exp_r.result, exp_r.less, exp_r.equal, exp_r.greater,
                         exp_r.dz));
      end
    endtask
  endclass

endpackage

### sim/tb.sv
// Top of the fixed-point ALU testbench: stimulus, prediction and checking.
`timescale 1ns / 100ps
module tb;
  import fpa_pkg::*;
  import tb_fpa_sb_pkg::*;

  localparam int FB        = 8;
  localparam int LATENCY   = FB + 34;
  localparam int N_RANDOM  = 1650;
  localparam int CYC_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cyc = 0;
  bit   quiet_tail = 1'b0;   // no idling near the end
  bit   hold_off = 1'b0;     // long receiver stall already taken
  bit   stim_done = 1'b0;

  fpa_in_if  in_ch ();
  fpa_out_if out_ch ();

  fixed_point_q24_8_alu_core #(.FRACTION_BITS(FB)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  alu_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.action    = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready    = 1'b0;
  end

  // Predict one item's result from action and the two raw operands.
  function automatic alu_res_t alu_predict(logic [3:0] act, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_res_t r;
    logic signed [63:0] prod;
    logic signed [63:0] dividend;
    logic signed [63:0] quo;
    r.dz = 1'b0;
    r.result = '0;
    case (act)
      ACT_ADD:      r.result = a + b;
      ACT_SUB:      r.result = a - b;
      ACT_MUL: begin
        prod = 64'(a) * 64'(b);
        r.result = 32'(prod >>> FB);
      end
      ACT_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          dividend = 64'(a) <<< FB;
          quo = dividend / 64'(b);   // truncates toward zero
          r.result = 32'(quo);
        end
      end
      ACT_MIN:      r.result = (a < b) ? a : b;
      ACT_MAX:      r.result = (a > b) ? a : b;
      ACT_INC:      r.result = a + 32'sd1;
      ACT_DEC:      r.result = a - 32'sd1;
      ACT_FROM_INT: r.result = a <<< FB;
      ACT_TO_INT:   r.result = a >>> FB;
      default:      r.result = '0;   // unused codes
    endcase
    r.less    = a < b;
    r.equal   = a == b;
    r.greater = a > b;
    return r;
  endfunction

  // Offer one item and hold it until accepted; at times a burst of idle before it.
  task automatic send_item(logic [3:0] act, logic signed [31:0] a, logic signed [31:0] b);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(alu_predict(act, a, b));
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 2000)) - 1000);
      3: return '0;
      4: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Stimulus: directed corners, then random items.
  initial begin
    logic [3:0] act;
    logic [31:0] a, b;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // each action at the extremes
    for (int k = 0; k <= 9; k++) begin
      send_item(4'(k), 32'h7fff_ffff, 32'h8000_0000);
      send_item(4'(k), 32'h8000_0000, 32'hffff_ffff);  // most negative by minus one
    end
    send_item(ACT_DIV, 32'h0000_0500, 32'h0);          // divide by zero
    send_item(ACT_DIV, 32'hffff_fb00, 32'h0000_0300);  // negative quotient truncation
    send_item(4'd12, 32'h1234, 32'h1234);              // unused code, equal operands
    send_item(4'd15, 32'h1, 32'h2);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 200) quiet_tail = 1'b1;
      act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
      a = rand_operand();
      b = ($urandom_range(0, 9) == 0) ? a : rand_operand();
      if (act == ACT_DIV && $urandom_range(0, 9) == 0) b = '0;
      send_item(act, a, b);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls plus one long hold-off to fill the pipeline.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (cyc >= 600 && !hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (150) @(posedge clk);
        hold_off = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Check each accepted result item.
  always @(posedge clk) begin
    alu_res_t got;
    cyc <= cyc + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.result  = out_ch.result;
      got.less    = out_ch.less;
      got.equal   = out_ch.equal;
      got.greater = out_ch.greater;
      got.dz      = out_ch.divide_by_zero;
      sb.check_result(got);
    end
  end

  // End of run and timeout.
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0 && cyc < CYC_LIMIT) @(posedge clk);
    if (cyc < CYC_LIMIT) repeat (LATENCY * 2) @(posedge clk);
    if (cyc >= CYC_LIMIT) begin
      $display("fixed_point_q24_8_alu_core verification failed");
    end else if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("fixed_point_q24_8_alu_core verification clean");
    end else begin
      $display("fixed_point_q24_8_alu_core verification failed");
    end
    $finish;
  end

  initial begin
    wait (cyc >= CYC_LIMIT + LATENCY * 4);
    $display("fixed_point_q24_8_alu_core verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/fpa_pkg.sv
rtl/fpa_if.sv
rtl/fpa_front.sv
rtl/fpa_queue.sv
rtl/fpa_back.sv
rtl/fixed_point_q24_8_alu_core.sv
sim/tb_fpa_if.sv
sim/tb.sv
